[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh - assertion helpers for the display bus sequencer
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define LCDSEQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition that must never be true outside reset.
`define LCDSEQ_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define LCDSEQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define LCDSEQ_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

[rtl/lcdseq_pkg.sv]
// ----------------------------------------------------------------------------
// lcdseq_pkg - shared types and constants
// Item formats, opcodes, register indexes and display command bytes.
// ----------------------------------------------------------------------------
package lcdseq_pkg;

    // request opcodes
    localparam logic [2:0] OP_CMD   = 3'd0;
    localparam logic [2:0] OP_DATA  = 3'd1;
    localparam logic [2:0] OP_INIT  = 3'd2;
    localparam logic [2:0] OP_CURSOR = 3'd3;
    localparam logic [2:0] OP_CLEAR = 3'd4;
    localparam logic [2:0] OP_HOME  = 3'd5;

    // configuration register indexes
    localparam logic [2:0] CFG_BUS_8BIT    = 3'd0;
    localparam logic [2:0] CFG_TWO_LINES   = 3'd1;
    localparam logic [2:0] CFG_LARGE_FONT  = 3'd2;
    localparam logic [2:0] CFG_LINE_COUNT  = 3'd3;
    localparam logic [2:0] CFG_ROW_OFFSET0 = 3'd4;
    localparam logic [2:0] CFG_ROW_OFFSET1 = 3'd5;
    localparam logic [2:0] CFG_ROW_OFFSET2 = 3'd6;
    localparam logic [2:0] CFG_ROW_OFFSET3 = 3'd7;

    localparam int CFG_DATA_W = 7;

    // display command bytes and bits
    localparam logic [7:0] CMD_CLEAR      = 8'h01;
    localparam logic [7:0] CMD_HOME       = 8'h02;
    localparam logic [7:0] LCD_WAKE_NIB   = 8'h03;
    localparam logic [7:0] LCD_FONT_5X10  = 8'h04;
    localparam logic [7:0] LCD_TWO_LINE   = 8'h08;
    localparam logic [7:0] LCD_BUS_8BIT   = 8'h10;
    localparam logic [7:0] LCD_FUNC_SET   = 8'h20;
    localparam logic [7:0] LCD_SET_DDRAM  = 8'h80;
    localparam logic [7:0] CMD_DISPLAY_ON = 8'h0C;
    localparam logic [7:0] LCD_ENTRY_MODE = 8'h06;

    // waits in milliseconds
    localparam logic [6:0] WAIT_POWER_UP  = 7'd50;
    localparam logic [6:0] WAIT_LONG_CMD  = 7'd50;
    localparam logic [6:0] WAIT_WAKE_LONG = 7'd5;
    localparam logic [6:0] WAIT_WAKE_SHORT = 7'd1;

    localparam int STEP_W = 4;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] byte_value;
        logic [7:0] column;
        logic [7:0] row;
    } req_t;

    typedef struct packed {
        logic       register_select;
        logic [7:0] bus_value;
        logic [5:0] wait_before_ms;
        logic [5:0] wait_after_ms;
        logic       last;
    } strobe_t;

    typedef enum logic {
        JOB_BYTE,
        JOB_INIT
    } job_kind_t;

    // one classified request, as queued between front and back
    typedef struct packed {
        job_kind_t  kind;
        logic       rs;
        logic [7:0] value;      // byte to send, or function set for init
        logic       long_wait;  // extra settle after clear and home
    } job_t;

    function automatic logic [5:0] sat_wait(input logic [6:0] ms);
        return (ms > 7'd63) ? 6'd63 : ms[5:0];
    endfunction

endpackage

[rtl/lcdseq_front.sv]
// ----------------------------------------------------------------------------
// lcdseq_front - request intake and classification
// Holds the configuration registers and turns each request into a job.
// ----------------------------------------------------------------------------
module lcdseq_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [2:0]                           cfg_index,
    input  logic [lcdseq_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                                 start,
    input  lcdseq_pkg::req_t                     request,
    input  logic                                 full,
    output logic                                 push,
    output lcdseq_pkg::job_t                     job,
    output logic                                 bus_8bit
);

    logic       bus_8bit_reg;
    logic       two_lines_reg;
    logic       large_font_reg;
    logic [2:0] line_count_reg;
    logic [6:0] row_offset_reg [4];

    logic       known_op;
    logic [7:0] func_set;
    logic [2:0] lines;
    logic [1:0] row_sel;
    logic [6:0] ddram_addr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_8bit_reg      <= 1'b0;
            two_lines_reg     <= 1'b1;
            large_font_reg    <= 1'b0;
            line_count_reg    <= 3'd2;
            row_offset_reg[0] <= 7'd0;
            row_offset_reg[1] <= 7'd64;
            row_offset_reg[2] <= 7'd20;
            row_offset_reg[3] <= 7'd84;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lcdseq_pkg::CFG_BUS_8BIT:    bus_8bit_reg      <= cfg_data[0];
                lcdseq_pkg::CFG_TWO_LINES:   two_lines_reg     <= cfg_data[0];
                lcdseq_pkg::CFG_LARGE_FONT:  large_font_reg    <= cfg_data[0];
                lcdseq_pkg::CFG_LINE_COUNT:  line_count_reg    <= cfg_data[2:0];
                lcdseq_pkg::CFG_ROW_OFFSET0: row_offset_reg[0] <= cfg_data;
                lcdseq_pkg::CFG_ROW_OFFSET1: row_offset_reg[1] <= cfg_data;
                lcdseq_pkg::CFG_ROW_OFFSET2: row_offset_reg[2] <= cfg_data;
                lcdseq_pkg::CFG_ROW_OFFSET3: row_offset_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // function set byte from the current bus and font settings
    always_comb
    begin
        func_set = lcdseq_pkg::LCD_FUNC_SET;
        if (bus_8bit_reg)
            func_set = func_set | lcdseq_pkg::LCD_BUS_8BIT;
        if (two_lines_reg)
            func_set = func_set | lcdseq_pkg::LCD_TWO_LINE;
        if (large_font_reg)
            func_set = func_set | lcdseq_pkg::LCD_FONT_5X10;
    end

    // clamp the row to three, then to the last line in use
    always_comb
    begin
        lines   = (line_count_reg == 3'd0) ? 3'd1 : line_count_reg;
        row_sel = (request.row >= 8'd4) ? 2'd3 : request.row[1:0];
        if ({1'b0, row_sel} >= lines)
            row_sel = 2'(lines - 3'd1);
        ddram_addr = request.column[6:0] + row_offset_reg[row_sel];
    end

    always_comb
    begin
        known_op      = 1'b1;
        job.kind      = lcdseq_pkg::JOB_BYTE;
        job.rs        = 1'b0;
        job.value     = request.byte_value;
        job.long_wait = 1'b0;
        unique case (request.opcode)
            lcdseq_pkg::OP_CMD: ;
            lcdseq_pkg::OP_DATA:
                job.rs = 1'b1;
            lcdseq_pkg::OP_INIT:
            begin
                job.kind  = lcdseq_pkg::JOB_INIT;
                job.value = func_set;
            end
            lcdseq_pkg::OP_CURSOR:
                job.value = lcdseq_pkg::LCD_SET_DDRAM | {1'b0, ddram_addr};
            lcdseq_pkg::OP_CLEAR:
            begin
                job.value     = lcdseq_pkg::CMD_CLEAR;
                job.long_wait = 1'b1;
            end
            lcdseq_pkg::OP_HOME:
            begin
                job.value     = lcdseq_pkg::CMD_HOME;
                job.long_wait = 1'b1;
            end
            default:
                known_op = 1'b0;
        endcase
    end

    // drop unknown opcodes: they produce no strobes
    assign push     = start && !full && known_op;
    assign bus_8bit = bus_8bit_reg;

endmodule

[rtl/lcdseq_queue.sv]
// ----------------------------------------------------------------------------
// lcdseq_queue - job queue between front and back
// Small register FIFO; the head entry is the job being carried out.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lcdseq_queue #(
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  lcdseq_pkg::job_t push_job,
    input  logic             pop,
    output logic             full,
    output logic             head_valid,
    output lcdseq_pkg::job_t head_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lcdseq_pkg::job_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] ptr);
        return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + 1'b1;
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = entry_reg[rd_ptr_reg];

    `LCDSEQ_NEVER(a_no_push_full, clk, rst_n, push && full, "push into full job queue")
    `LCDSEQ_NEVER(a_no_pop_empty, clk, rst_n, pop && !head_valid, "pop from empty job queue")

endmodule

[rtl/lcdseq_back.sv]
// ----------------------------------------------------------------------------
// lcdseq_back - strobe sequencer
// Expands the job at the queue head into one strobe per cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lcdseq_back #(
    parameter int PULSE_MS = 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  job_valid,
    input  lcdseq_pkg::job_t      job,
    input  logic                  bus_8bit,
    output logic                  pop,
    output logic                  result_strobe,
    output lcdseq_pkg::strobe_t   result
);

    localparam int SW = lcdseq_pkg::STEP_W;

    logic [SW-1:0]       step_reg, step_next;
    logic                strobe_reg;
    lcdseq_pkg::strobe_t result_reg, result_next;

    logic [SW-1:0] last_step;
    logic [SW-1:0] rel;
    logic [1:0]    pre_idx;
    logic [1:0]    byte_idx;
    logic          lo_half;
    logic          preamble;
    logic [7:0]    cur_byte;
    logic [6:0]    extra;
    logic [5:0]    settle;

    function automatic logic [5:0] settle_after(input logic [6:0] add);
        return lcdseq_pkg::sat_wait(7'(PULSE_MS) + add);
    endfunction

    always_comb
    begin
        if (job.kind == lcdseq_pkg::JOB_INIT)
            last_step = bus_8bit ? SW'(5) : SW'(9);
        else
            last_step = bus_8bit ? SW'(0) : SW'(1);

        // position within the init run: preamble first, then three bytes
        rel      = step_reg - (bus_8bit ? SW'(3) : SW'(4));
        pre_idx  = step_reg[1:0];
        preamble = bus_8bit ? (step_reg < SW'(3)) : (step_reg < SW'(4));
        byte_idx = bus_8bit ? rel[1:0] : rel[2:1];

        cur_byte = job.value;
        extra    = '0;
        lo_half  = step_reg[0];
        if (job.kind == lcdseq_pkg::JOB_INIT)
        begin
            lo_half = rel[0];
            unique case (byte_idx)
                2'd0:    cur_byte = job.value;
                2'd1:    cur_byte = lcdseq_pkg::CMD_DISPLAY_ON;
                default: cur_byte = lcdseq_pkg::LCD_ENTRY_MODE;
            endcase
        end
        else if (job.long_wait)
            extra = lcdseq_pkg::WAIT_LONG_CMD;
        settle = settle_after(extra);

        result_next.register_select = job.rs;
        result_next.wait_before_ms  = '0;
        result_next.last            = (step_reg == last_step);
        if (job.kind == lcdseq_pkg::JOB_INIT && preamble)
        begin
            if (pre_idx == 2'd0)
                result_next.wait_before_ms = lcdseq_pkg::WAIT_POWER_UP[5:0];
            if (bus_8bit)
            begin
                result_next.bus_value = job.value;
                unique case (pre_idx)
                    2'd0:    result_next.wait_after_ms =
                                 settle_after(lcdseq_pkg::WAIT_WAKE_LONG);
                    2'd1:    result_next.wait_after_ms =
                                 settle_after(lcdseq_pkg::WAIT_WAKE_SHORT);
                    default: result_next.wait_after_ms = settle_after('0);
                endcase
            end
            else
            begin
                result_next.bus_value = (pre_idx == 2'd3) ?
                    (lcdseq_pkg::LCD_FUNC_SET >> 4) : lcdseq_pkg::LCD_WAKE_NIB;
                unique case (pre_idx)
                    2'd0, 2'd1: result_next.wait_after_ms =
                                    lcdseq_pkg::WAIT_WAKE_LONG[5:0];
                    2'd2:       result_next.wait_after_ms =
                                    lcdseq_pkg::WAIT_WAKE_SHORT[5:0];
                    default:    result_next.wait_after_ms = '0;
                endcase
            end
        end
        else if (bus_8bit)
        begin
            result_next.bus_value     = cur_byte;
            result_next.wait_after_ms = settle;
        end
        else if (lo_half)
        begin
            result_next.bus_value     = {4'h0, cur_byte[3:0]};
            result_next.wait_after_ms = settle;
        end
        else
        begin
            result_next.bus_value     = {4'h0, cur_byte[7:4]};
            result_next.wait_after_ms = '0;
        end

        pop       = job_valid && result_next.last;
        step_next = step_reg;
        if (job_valid)
            step_next = pop ? '0 : step_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            step_reg   <= step_next;
            strobe_reg <= job_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_valid)
            result_reg <= result_next;
    end

    assign result_strobe = strobe_reg;
    assign result        = result_reg;

    `LCDSEQ_ASSERT(a_pop_rewinds, clk, rst_n, pop |=> (step_reg == '0), "step not rewound")
    `LCDSEQ_ASSERT(a_mid_job_held, clk, rst_n, (step_reg != '0) |-> job_valid, "job lost mid run")
    `LCDSEQ_ASSERT(a_step_bound, clk, rst_n, step_reg <= SW'(9), "step past longest run")

endmodule

[rtl/char_lcd_bus_sequencer_unit.sv]
// ----------------------------------------------------------------------------
// char_lcd_bus_sequencer_unit - character display bus sequencer
// Expands display requests into timed enable strobes for the panel driver.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive request and raise start; the item is taken at a
//   rising edge with start high and busy low. busy rises only while the job
//   queue is full. Opcodes six and seven are taken and dropped.
//   Result channel: each strobe shows on result for exactly one cycle with
//   result_strobe high; result.last marks the final strobe of a request.
//   The receiver cannot stall, so the sequencer never waits on it.
//   Config port: cfg_we writes cfg_data into register cfg_index at once;
//   change it only while no request is pending.
// Timing:
//   With the queue empty, the accept edge writes the request into the queue
//   and the first strobe is then registered from the queue head. Strobes
//   follow one per cycle while a job is queued: a byte request gives one
//   strobe on the eight-bit bus and two on the nibble bus, init six or ten.
//   The back sequencer sets the throughput while the queue takes requests.
// Reset:
//   Clears the queue and sequencer and loads the register defaults: nibble
//   bus, two lines, small font, two lines in use, rows at 0, 64, 20, 84.
// ----------------------------------------------------------------------------
module char_lcd_bus_sequencer_unit #(
    parameter int PULSE_MS    = 1,   // settle after each byte, 1 to 16 ms
    parameter int QUEUE_DEPTH = 2    // queued requests, 2 or more
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [2:0]                         cfg_index,
    input  logic [lcdseq_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                               start,
    input  lcdseq_pkg::req_t                   request,
    output logic                               busy,
    output logic                               result_strobe,
    output lcdseq_pkg::strobe_t                result
);

    logic             push;
    logic             pop;
    logic             full;
    logic             head_valid;
    logic             bus_8bit;
    lcdseq_pkg::job_t push_job;
    lcdseq_pkg::job_t head_job;

    // classify requests and hold the registers
    lcdseq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .start     (start),
        .request   (request),
        .full      (full),
        .push      (push),
        .job       (push_job),
        .bus_8bit  (bus_8bit)
    );

    // decouple intake from strobe generation
    lcdseq_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    // walk the head job one strobe per cycle, pop on its last strobe
    lcdseq_back #(
        .PULSE_MS (PULSE_MS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .job_valid     (head_valid),
        .job           (head_job),
        .bus_8bit      (bus_8bit),
        .pop           (pop),
        .result_strobe (result_strobe),
        .result        (result)
    );

    // hold off new requests only while the queue has no room
    assign busy = full;

endmodule
